// ===== src/thtt_pkg.sv =====
package thtt_pkg;

  // fixed field widths
  localparam int COORD_W = 16;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;

  // default table depth
  localparam int MAX_QUADS_DEF = 64;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // input word
  typedef struct packed {
    logic                       kind;
    logic [INDEX_W-1:0]         entry_index;
    logic signed [COORD_W-1:0]  top_left_x;
    logic signed [COORD_W-1:0]  top_left_y;
    logic signed [COORD_W-1:0]  top_right_x;
    logic signed [COORD_W-1:0]  top_right_y;
    logic signed [COORD_W-1:0]  bottom_left_x;
    logic signed [COORD_W-1:0]  bottom_left_y;
    logic signed [COORD_W-1:0]  bottom_right_x;
    logic signed [COORD_W-1:0]  bottom_right_y;
    logic signed [COORD_W-1:0]  query_x;
    logic signed [COORD_W-1:0]  query_y;
  } item_t;

  // result word
  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] hit_index;
  } result_t;

  // one stored table entry
  typedef struct packed {
    logic signed [COORD_W-1:0] left_edge_x;
    logic signed [COORD_W-1:0] right_edge_x;
    logic signed [COORD_W-1:0] upper_left_y;
    logic signed [COORD_W-1:0] upper_right_y;
    logic signed [COORD_W-1:0] lower_left_y;
    logic signed [COORD_W-1:0] lower_right_y;
    logic signed [COORD_W-1:0] box_min_y;
    logic signed [COORD_W-1:0] box_max_y;
  } entry_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic write;
    logic issue;
    logic capture;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_query;
    logic count_zero;
    logic issue_done;
    logic hit_seen;
    logic last_seen;
  } dp_status_t;

endpackage

// ===== src/thtt_ram.sv =====
module thtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/thtt_ctrl.sv =====
module thtt_ctrl
  import thtt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  output logic       done,
  output ctrl_cmd_t  cmd,
  input  dp_status_t st
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    busy        = 1'b1;
    done        = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (!st.is_query) begin
            state_next = ST_WRITE;
          end else if (st.count_zero) begin
            state_next = ST_RESP;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_WRITE: begin
        cmd.write  = 1'b1;
        state_next = ST_RESP;
      end
      ST_SCAN: begin
        cmd.issue   = !st.issue_done;
        cmd.capture = 1'b1;
        if (st.hit_seen || st.last_seen) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/thtt_dp.sv =====
module thtt_dp
  import thtt_pkg::*;
#(
  parameter int MAX_QUADS = MAX_QUADS_DEF,
  localparam int AW = (MAX_QUADS > 1) ? $clog2(MAX_QUADS) : 1,
  localparam int CW = $clog2(MAX_QUADS + 1),
  localparam int NW = (CW > COUNT_W) ? CW : COUNT_W,
  localparam int IW = (AW > INDEX_W) ? AW : INDEX_W
) (
  input  logic               clk,
  input  logic               rst,
  input  item_t              item,
  output result_t            result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         st
);

  localparam int DW = COORD_W + 1;     // differences and widths
  localparam int PW = 2 * DW;          // products
  localparam int SW = PW + 1;          // sums of two products

  // configuration register
  logic [COUNT_W-1:0] quad_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quad_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      quad_count <= cfg_data;
    end
  end

  // searched count, clipped to the table depth
  logic [NW-1:0] n_eff;

  always_comb begin
    if (NW'(quad_count) > NW'(MAX_QUADS)) begin
      n_eff = NW'(MAX_QUADS);
    end else begin
      n_eff = NW'(quad_count);
    end
  end

  // latched item
  item_t in_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= item;
    end
  end

  // write path: orient left to right and form the y box
  entry_t        wentry;
  logic          swap;
  logic [IW-1:0] widx;
  logic          widx_ok;

  always_comb begin
    swap = in_r.top_left_x > in_r.top_right_x;
    if (swap) begin
      wentry.left_edge_x   = in_r.top_right_x;
      wentry.right_edge_x  = in_r.top_left_x;
      wentry.upper_left_y  = in_r.top_right_y;
      wentry.upper_right_y = in_r.top_left_y;
      wentry.lower_left_y  = in_r.bottom_right_y;
      wentry.lower_right_y = in_r.bottom_left_y;
    end else begin
      wentry.left_edge_x   = in_r.top_left_x;
      wentry.right_edge_x  = in_r.top_right_x;
      wentry.upper_left_y  = in_r.top_left_y;
      wentry.upper_right_y = in_r.top_right_y;
      wentry.lower_left_y  = in_r.bottom_left_y;
      wentry.lower_right_y = in_r.bottom_right_y;
    end
    wentry.box_min_y = (wentry.upper_left_y < wentry.upper_right_y) ?
                       wentry.upper_left_y : wentry.upper_right_y;
    wentry.box_max_y = (wentry.lower_left_y > wentry.lower_right_y) ?
                       wentry.lower_left_y : wentry.lower_right_y;
    widx    = IW'(in_r.entry_index);
    widx_ok = 32'(in_r.entry_index) < 32'(MAX_QUADS);
  end

  // scan counter
  logic [NW-1:0] k;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k <= '0;
    end else if (cmd.issue) begin
      k <= k + NW'(1);
    end
  end

  // table memory
  entry_t rentry;

  thtt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_QUADS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.write && widx_ok),
    .waddr (widx[AW-1:0]),
    .wdata (wentry),
    .raddr (k[AW-1:0]),
    .rdata (rentry)
  );

  // stage 0: read in flight
  logic          v0, last0;
  logic [AW-1:0] tag0;

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      v0 <= 1'b0;
    end else begin
      v0 <= cmd.issue;
    end
    tag0  <= k[AW-1:0];
    last0 <= (k == n_eff - NW'(1));
  end

  // stage 1: range checks and differences
  logic                 v1, last1, ok1;
  logic [AW-1:0]        tag1;
  logic signed [DW-1:0] w1, d1, dyu1, dyl1;
  logic signed [COORD_W-1:0] ul1, ll1, py1;
  logic signed [COORD_W-1:0] px, py;

  assign px = in_r.query_x;
  assign py = in_r.query_y;

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    tag1  <= tag0;
    last1 <= last0;
    ok1   <= (rentry.right_edge_x > rentry.left_edge_x) &&
             (py >= rentry.box_min_y) && (py <= rentry.box_max_y) &&
             (px >= rentry.left_edge_x) && (px <= rentry.right_edge_x);
    w1    <= DW'(rentry.right_edge_x) - DW'(rentry.left_edge_x);
    d1    <= DW'(px) - DW'(rentry.left_edge_x);
    dyu1  <= DW'(rentry.upper_right_y) - DW'(rentry.upper_left_y);
    dyl1  <= DW'(rentry.lower_right_y) - DW'(rentry.lower_left_y);
    ul1   <= rentry.upper_left_y;
    ll1   <= rentry.lower_left_y;
    py1   <= py;
  end

  // stage 2: cross products
  logic                 v2, last2, ok2;
  logic [AW-1:0]        tag2;
  logic signed [PW-1:0] p_du, p_uw, p_dl, p_lw, p_yw;

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    tag2  <= tag1;
    last2 <= last1;
    ok2   <= ok1;
    p_du  <= PW'(d1) * PW'(dyu1);
    p_uw  <= PW'(ul1) * PW'(w1);
    p_dl  <= PW'(d1) * PW'(dyl1);
    p_lw  <= PW'(ll1) * PW'(w1);
    p_yw  <= PW'(py1) * PW'(w1);
  end

  // stage 3: edge compares
  logic                 v3, last3, hit3;
  logic [AW-1:0]        tag3;
  logic signed [SW-1:0] lhs_u, lhs_l, rhs;

  always_comb begin
    lhs_u = SW'(p_du) + SW'(p_uw);
    lhs_l = SW'(p_dl) + SW'(p_lw);
    rhs   = SW'(p_yw);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    tag3  <= tag2;
    last3 <= last2;
    hit3  <= ok2 && (lhs_u <= rhs) && (lhs_l > rhs);
  end

  // first hit capture
  logic          found_r;
  logic [IW-1:0] hit_wide;
  logic [INDEX_W-1:0] hit_r;

  assign hit_wide = IW'(tag3);

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      found_r <= 1'b0;
      hit_r   <= '0;
    end else if (cmd.capture && v3 && hit3 && !found_r) begin
      found_r <= 1'b1;
      hit_r   <= hit_wide[INDEX_W-1:0];
    end
  end

  assign result.found     = found_r;
  assign result.hit_index = hit_r;

  // status to controller
  always_comb begin
    st.is_query   = (item.kind == KIND_QUERY);
    st.count_zero = (n_eff == '0);
    st.issue_done = (k == n_eff);
    st.hit_seen   = v3 && hit3;
    st.last_seen  = v3 && last3;
  end

endmodule

// ===== src/trapezoid_hit_test_table_core.sv =====
// Trapezoid hit-test table.
// Items enter on start/item and are taken at an edge with start high and busy
// low. A write item stores one quad (vertical left and right edges) in its
// slot; a query item searches slots 0 .. n-1 (n = quad_count clipped to
// MAX_QUADS) for the first quad that holds the point. Every item gives one
// result word on result, marked by done for exactly one cycle; the receiver
// cannot stall, so the word must be taken then. busy stays high from the
// accept until the done cycle ends. quad_count is written over cfg_valid/
// cfg_ready/cfg_data, always ready; the user must write it only while the
// block is idle, the block does not enforce this. A write passes the write
// state before done; a query with quad_count zero goes straight to done. A
// query streams one table entry per cycle out of the single read port of the
// table memory into a four-stage compare pipeline and stops at the first hit
// or the last entry. One item is in work at a time.
// Reset clears the controller, the pipeline and quad_count; table contents
// are not cleared and a slot must be written before a query reaches it.
module trapezoid_hit_test_table_core
  import thtt_pkg::*;
#(
  parameter int MAX_QUADS = MAX_QUADS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  item_t              item,
  output logic               done,
  output result_t            result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  // sequencer
  thtt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .st    (st)
  );

  // table and compare pipeline
  thtt_dp #(
    .MAX_QUADS (MAX_QUADS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// ===== src/thtt_checker.sv =====
module thtt_checker
  import thtt_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input item_t   item,
  input logic    done,
  input result_t result
);

  // a result word only comes while an item is in work
  assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done while not busy");

  // an accepted word makes the block busy
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("not busy after accept");

  // done lasts one cycle
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");

  // a write answers with no hit
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.kind == KIND_WRITE) |-> ##2 (done && !result.found))
    else $error("write result missing or wrong");

  // a miss reports index zero
  assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> (result.hit_index == '0))
    else $error("nonzero index without hit");

endmodule

bind trapezoid_hit_test_table_core thtt_checker u_checker (.*);
